// ----- design/evar_pkg.sv -----
// ----------------------------------------------------------------------------
// evar_pkg: shared types and constants of the voice activity recorder
// Field widths, register indexes, event codes and the records that pass
// between the front end, the back end and the two queues.
// ----------------------------------------------------------------------------
package evar_pkg;

  localparam int SAMPLE_W   = 16;  // microphone sample
  localparam int LEVEL_W    = 16;  // voice and quiet levels
  localparam int INDEX_W    = 18;  // buffer write index
  localparam int COUNT_W    = 19;  // recorded count, limits, lengths
  localparam int RUN_W      = 20;  // silence run, saturating
  localparam int CNT_W      = 11;  // samples in a frame, up to 1024
  localparam int SUM_W      = 26;  // sum of magnitudes over a frame
  localparam int PROD_W     = 28;  // level times frame length
  localparam int CFG_DATA_W = 19;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VOICE_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd3;

  localparam logic [LEVEL_W-1:0] VOICE_LEVEL_RST   = 16'd1000;
  localparam logic [LEVEL_W-1:0] QUIET_LEVEL_RST   = 16'd500;
  localparam logic [COUNT_W-1:0] SILENCE_LIMIT_RST = 19'd16000;
  localparam logic [COUNT_W-1:0] MIN_LENGTH_RST    = 19'd12800;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_DONE  = 2'd2,
    EV_SHORT = 2'd3
  } event_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] voice_level;
    logic [LEVEL_W-1:0] quiet_level;
    logic [COUNT_W-1:0] silence_limit;
    logic [COUNT_W-1:0] min_length;
  } cfg_t;

  // One classified sample; sum and cnt include this sample.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic [SUM_W-1:0]           sum;
    logic [CNT_W-1:0]           cnt;
  } entry_t;

  typedef struct packed {
    logic                       store_enable;
    logic [INDEX_W-1:0]         store_index;
    logic signed [SAMPLE_W-1:0] store_value;
    event_t                     event_code;
    logic [COUNT_W-1:0]         utterance_length;
  } result_t;

endpackage

// ----- design/evar_queue.sv -----
// ----------------------------------------------------------------------------
// evar_queue: small first-in first-out queue
// Register-based storage with wrap-around pointers and an occupancy count.
// ----------------------------------------------------------------------------
module evar_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] occ;
  logic             do_push;
  logic             do_pop;

  assign full    = (occ == FULL_OCC);
  assign empty   = (occ == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        occ <= occ + 1'b1;
      end else if (do_pop && !do_push) begin
        occ <= occ - 1'b1;
      end
    end
  end

endmodule

// ----- design/evar_front.sv -----
// ----------------------------------------------------------------------------
// evar_front: sample intake and frame accumulation
// Accumulates the absolute level and length of the running frame, marks
// the last sample of each frame and hands every sample on as one entry.
// ----------------------------------------------------------------------------
module evar_front #(
  parameter int FRAME_MAX = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic signed [evar_pkg::SAMPLE_W-1:0] pcm_sample,
  input  logic                                 frame_end,
  input  logic                                 q_full,
  output logic                                 q_push,
  output evar_pkg::entry_t                     q_entry
);
  import evar_pkg::*;

  localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(FRAME_MAX);

  logic [SUM_W-1:0]   frame_sum;
  logic [CNT_W-1:0]   frame_cnt;
  logic [LEVEL_W-1:0] mag;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   cnt_next;
  logic               last;

  // Magnitude of the most negative sample is 32768, still 16 bits unsigned.
  assign mag      = pcm_sample[SAMPLE_W-1] ? (~pcm_sample + 1'b1) : pcm_sample;
  assign sum_next = frame_sum + SUM_W'(mag);
  assign cnt_next = frame_cnt + 1'b1;
  assign last     = frame_end || (cnt_next >= FRAME_LIMIT);

  assign q_push         = push && !q_full;
  assign q_entry.sample = pcm_sample;
  assign q_entry.last   = last;
  assign q_entry.sum    = sum_next;
  assign q_entry.cnt    = cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum <= '0;
      frame_cnt <= '0;
    end else if (q_push) begin
      frame_sum <= last ? '0 : sum_next;
      frame_cnt <= last ? '0 : cnt_next;
    end
  end

endmodule

// ----- design/evar_back.sv -----
// ----------------------------------------------------------------------------
// evar_back: recording control
// Stores samples while recording and, at each frame end, decides on start,
// silence run, end of utterance, trimming and discard.
// ----------------------------------------------------------------------------
module evar_back #(
  parameter int BUFFER_SAMPLES = 262144
) (
  input  logic              clk,
  input  logic              rst,
  input  evar_pkg::cfg_t    cfg,
  input  logic              head_valid,
  input  evar_pkg::entry_t  head,
  output logic              head_pop,
  input  logic              out_full,
  output logic              res_push,
  output evar_pkg::result_t res
);
  import evar_pkg::*;

  localparam logic [COUNT_W-1:0] BUF_COUNT = COUNT_W'(BUFFER_SAMPLES);

  typedef enum logic [1:0] {
    B_RUN,
    B_CMP,
    B_END
  } bstate_t;

  bstate_t                    state;
  logic                       rec_mode;
  logic [COUNT_W-1:0]         rec_count;
  logic [RUN_W-1:0]           silent_run;

  // frame-end working registers
  logic                       l_en;
  logic [INDEX_W-1:0]         l_idx;
  logic signed [SAMPLE_W-1:0] l_val;
  logic [SUM_W-1:0]           l_sum;
  logic [CNT_W-1:0]           l_n;
  logic [PROD_W-1:0]          prod_v;
  logic [PROD_W-1:0]          prod_q;
  logic                       loud;
  logic                       quiet;
  logic [RUN_W-1:0]           run_cand;
  logic [COUNT_W-1:0]         trim;
  logic                       trim_short;
  logic                       full_short;

  logic                       store_ok;
  logic [LEVEL_W:0]           voice_p1;
  logic [RUN_W:0]             run_sum;
  logic [COUNT_W-1:0]         trim_next;
  logic [RUN_W-1:0]           run_new;
  logic                       hit_limit;
  logic                       done;

  assign store_ok  = rec_mode && (rec_count < BUF_COUNT);
  assign voice_p1  = {1'b0, cfg.voice_level} + 1'b1;
  assign run_sum   = {1'b0, silent_run} + (RUN_W + 1)'(l_n);
  assign trim_next = (rec_count > cfg.silence_limit) ? (rec_count - cfg.silence_limit) : '0;
  assign run_new   = quiet ? run_cand : '0;
  assign hit_limit = ({1'b0, cfg.silence_limit} <= run_new);
  assign done      = (rec_count >= BUF_COUNT) || hit_limit;

  assign head_pop = (state == B_RUN) && head_valid && (head.last || !out_full);
  assign res_push = ((state == B_RUN) && head_valid && !head.last && !out_full) ||
                    ((state == B_END) && !out_full);

  always_comb begin
    res = '0;
    if (state == B_END) begin
      res.store_enable = l_en;
      res.store_index  = l_idx;
      res.store_value  = l_val;
      if (!rec_mode) begin
        res.event_code = loud ? EV_START : EV_NONE;
      end else if (done) begin
        if (hit_limit) begin
          res.event_code       = trim_short ? EV_SHORT : EV_DONE;
          res.utterance_length = trim;
        end else begin
          res.event_code       = full_short ? EV_SHORT : EV_DONE;
          res.utterance_length = rec_count;
        end
      end
    end else if (store_ok) begin
      res.store_enable = 1'b1;
      res.store_index  = rec_count[INDEX_W-1:0];
      res.store_value  = head.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_RUN;
      rec_mode   <= 1'b0;
      rec_count  <= '0;
      silent_run <= '0;
    end else begin
      unique case (state)
        B_RUN: begin
          if (head_pop) begin
            if (store_ok) begin
              rec_count <= rec_count + 1'b1;
            end
            if (head.last) begin
              l_en   <= store_ok;
              l_idx  <= store_ok ? rec_count[INDEX_W-1:0] : '0;
              l_val  <= store_ok ? head.sample : '0;
              l_sum  <= head.sum;
              l_n    <= head.cnt;
              prod_v <= PROD_W'(voice_p1) * PROD_W'(head.cnt);
              prod_q <= PROD_W'(cfg.quiet_level) * PROD_W'(head.cnt);
              state  <= B_CMP;
            end
          end
        end
        B_CMP: begin
          // mean > voice  <=>  sum >= (voice + 1) * n; mean < quiet <=> sum < quiet * n
          loud       <= (PROD_W'(l_sum) >= prod_v);
          quiet      <= (PROD_W'(l_sum) < prod_q);
          run_cand   <= run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
          trim       <= trim_next;
          trim_short <= (trim_next < cfg.min_length);
          full_short <= (rec_count < cfg.min_length);
          state      <= B_END;
        end
        B_END: begin
          if (!out_full) begin
            if (!rec_mode) begin
              if (loud) begin
                rec_mode   <= 1'b1;
                rec_count  <= '0;
                silent_run <= '0;
              end
            end else begin
              silent_run <= run_new;
              if (done) begin
                rec_mode <= 1'b0;
                if (hit_limit) begin
                  rec_count <= trim;
                end
              end
            end
            state <= B_RUN;
          end
        end
        default: state <= B_RUN;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_index_in_buffer: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.store_enable) |-> ({1'b0, res.store_index} < BUF_COUNT))
    else $error("store index beyond buffer");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    rec_count <= BUF_COUNT)
    else $error("recorded count beyond buffer");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res.event_code == EV_START)) |=> (rec_mode && (rec_count == '0)))
    else $error("start event without entering recording");

  a_end_leaves: assert property (@(posedge clk) disable iff (rst)
    (res_push && ((res.event_code == EV_DONE) || (res.event_code == EV_SHORT)))
      |=> !rec_mode)
    else $error("end event while still recording");

endmodule

// ----- design/energy_voice_activity_recorder_core.sv -----
// ----------------------------------------------------------------------------
// energy_voice_activity_recorder_core: energy voice activity recorder
// Frame-level voice detection with silence hangover, utterance capture
// indexes, trailing-silence trim and short-utterance discard.
// ----------------------------------------------------------------------------
// Use:
//   Input side is a queue: drive pcm_sample and frame_end, raise push; a beat
//   is taken at a rising edge with push high and full low.
//   Result side is a queue: while empty is low the oldest result sits on the
//   result ports; pop high at a rising edge takes that beat.
//   Every input beat yields exactly one result beat, in order.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register at
//   that edge; write only while the block is idle.
// Throughput: one sample per cycle inside a frame while the result queue is
//   not full; each frame end passes the control stage through its multiply,
//   compare and decide steps. The 4-entry input queue takes samples in the
//   meantime and raises full once it fills.
// Reset: rst clears both queues, the frame accumulator and the recording
//   state and loads the register defaults.
// Stall: with the result queue full the control stage holds; the input
//   queue fills behind it and full rises. No beat is ever dropped.
// ----------------------------------------------------------------------------
module energy_voice_activity_recorder_core #(
  parameter int BUFFER_SAMPLES = 262144,
  parameter int FRAME_MAX      = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample queue
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [evar_pkg::SAMPLE_W-1:0]   pcm_sample,
  input  logic                                   frame_end,
  // result queue
  output logic                                   empty,
  input  logic                                   pop,
  output logic                                   store_enable,
  output logic [evar_pkg::INDEX_W-1:0]           store_index,
  output logic signed [evar_pkg::SAMPLE_W-1:0]   store_value,
  output logic [1:0]                             event_code,
  output logic [evar_pkg::COUNT_W-1:0]           utterance_length,
  // configuration
  input  logic                                   cfg_write,
  input  logic [evar_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [evar_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import evar_pkg::*;

  localparam int ENTRY_DEPTH  = 4;
  localparam int RESULT_DEPTH = 2;

  cfg_t    cfg;
  logic    fq_push;
  entry_t  fq_wdata;
  logic    fq_full;
  entry_t  fq_rdata;
  logic    fq_empty;
  logic    fq_pop;
  logic    rq_push;
  logic    rq_full;
  result_t rq_wdata;
  result_t rq_rdata;

  // Configuration registers: take the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.voice_level   <= VOICE_LEVEL_RST;
      cfg.quiet_level   <= QUIET_LEVEL_RST;
      cfg.silence_limit <= SILENCE_LIMIT_RST;
      cfg.min_length    <= MIN_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VOICE_LEVEL:   cfg.voice_level   <= cfg_data[LEVEL_W-1:0];
        REG_QUIET_LEVEL:   cfg.quiet_level   <= cfg_data[LEVEL_W-1:0];
        REG_SILENCE_LIMIT: cfg.silence_limit <= cfg_data[COUNT_W-1:0];
        REG_MIN_LENGTH:    cfg.min_length    <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  // Front: accumulate frame level, mark frame ends.
  evar_front #(
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pcm_sample (pcm_sample),
    .frame_end  (frame_end),
    .q_full     (fq_full),
    .q_push     (fq_push),
    .q_entry    (fq_wdata)
  );

  assign full = fq_full;

  // Decouple intake from the frame-end decision stall.
  evar_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_DEPTH)
  ) u_entry_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // Back: store while recording, decide at frame ends.
  evar_back #(
    .BUFFER_SAMPLES (BUFFER_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (!fq_empty),
    .head       (fq_rdata),
    .head_pop   (fq_pop),
    .out_full   (rq_full),
    .res_push   (rq_push),
    .res        (rq_wdata)
  );

  // Hold finished results until the receiver pops them.
  evar_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign store_enable     = rq_rdata.store_enable;
  assign store_index      = rq_rdata.store_index;
  assign store_value      = rq_rdata.store_value;
  assign event_code       = rq_rdata.event_code;
  assign utterance_length = rq_rdata.utterance_length;

endmodule
